// File: src/positional_array_list_macros.svh
// Assertion macros shared by the positional array list RTL.
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PAL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("positional_array_list: check failed");

// Check that a condition implies a consequence in the same cycle.
`define PAL_ASSERT_IMPL(label, ante, cons) \
    `PAL_ASSERT(label, (ante) |-> (cons))

// Check that a condition implies a consequence in the next cycle.
`define PAL_ASSERT_NEXT(label, ante, cons) \
    `PAL_ASSERT(label, (ante) |=> (cons))

`endif

// File: src/pal_pkg.sv
// Shared types and constants for the positional array list.
package pal_pkg;

    localparam int LIST_DEPTH = 128;
    localparam int VAL_W      = 32;
    localparam int OP_W       = 3;
    localparam int POS_W      = 7;
    localparam int TOTAL_W    = 8;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GROUP      = 16;
    localparam int NGRP       = (LIST_DEPTH + GROUP - 1) / GROUP;
    localparam int IN_RAW_W   = OP_W + POS_W + VAL_W;
    localparam int IN_W       = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = VAL_W + TOTAL_W + STAT_W;
    localparam int OUT_W      = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_DELETE = 3'd3,
        OP_UPDATE = 3'd4,
        OP_READ   = 3'd5
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_WRITE,
        CMD_INSERT,
        CMD_DELETE,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [CMP_W-1:0] pos;
        logic [CMP_W-1:0] count;
        logic [VAL_W-1:0] val;
    } pal_ctrl_t;

endpackage

// File: src/pal_cell.sv
// One list entry: loads, shifts from a neighbor, or holds, and drives its read tap.
module pal_cell
    import pal_pkg::*;
(
    input  logic             clk,
    input  pal_ctrl_t        ctrl,
    input  logic [CMP_W-1:0] index,
    input  logic [VAL_W-1:0] below,
    input  logic [VAL_W-1:0] above,
    output logic [VAL_W-1:0] value,
    output logic [VAL_W-1:0] tap
);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic [CMP_W-1:0] index_up;

    assign index_up = CMP_W'(index + 1'b1);

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.cmd)
            CMD_WRITE:
            begin
                if (index == ctrl.pos)
                    value_next = ctrl.val;
            end
            CMD_INSERT:
            begin
                if (index == ctrl.pos)
                    value_next = ctrl.val;
                else if (index > ctrl.pos && index <= ctrl.count)
                    value_next = below;
            end
            CMD_DELETE:
            begin
                if (index >= ctrl.pos && index_up < ctrl.count)
                    value_next = above;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = (ctrl.cmd == CMD_READ && index == ctrl.pos) ? value_reg : '0;

endmodule

// File: src/pal_fold.sv
// Registered two-level OR tree that collects the single active read tap.
module pal_fold
    import pal_pkg::*;
(
    input  logic             clk,
    input  logic             load,
    input  logic [VAL_W-1:0] leaf [LIST_DEPTH],
    output logic [VAL_W-1:0] sum
);

    logic [VAL_W-1:0] grp_reg  [NGRP];
    logic [VAL_W-1:0] grp_next [NGRP];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < LIST_DEPTH)
                    grp_next[g] = grp_next[g] | leaf[g * GROUP + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NGRP; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        sum = '0;
        for (int g = 0; g < NGRP; g++)
            sum = sum | grp_reg[g];
    end

endmodule

// File: src/positional_array_list.sv
// Top level of the positional array list: request decode, cell row and result register.
//
// Input channel s_*: one word per request (opcode, position, item value).
// Output channel m_*: one word per request (read value, element total, status).
// Every request gives exactly one result word, in request order.
// A request is taken in ST_IDLE, the cell row executes it in ST_EXEC,
// where the fold stage also registers the read taps, and the read value
// is loaded into the output register in ST_FOLD, which raises m_tvalid.
// s_tready is high only in ST_IDLE, so the next request is accepted only
// once the previous result has been loaded into the output register.
// Insert and delete shift every later entry one cell, all in the same cycle.
// After reset the list is empty; entries hold no defined value until written.
// The output register holds a result while m_tready is low; a request may
// be accepted meanwhile, and its result then waits in the fold stage until
// the output register is free.
module positional_array_list
    import pal_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // opcode[2:0], position[9:3], item_value[41:10], zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // read_value[31:0], element_total[39:32], status[41:40], zero
);

`include "positional_array_list_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FOLD
    } state_t;

    state_t             state_reg,  state_next;
    logic [OP_W-1:0]    op_reg,     op_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [VAL_W-1:0]   val_reg,    val_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    status_t            stat_reg,   stat_next;
    logic               ovalid_reg, ovalid_next;
    logic [VAL_W-1:0]   ord_reg,    ord_next;
    logic [TOTAL_W-1:0] otot_reg,   otot_next;
    status_t            ostat_reg,  ostat_next;

    pal_ctrl_t          ctrl;
    cmd_t               cmd;
    status_t            exec_stat;
    logic [CNT_W-1:0]   exec_count;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic               full;
    logic [VAL_W-1:0]   fold_sum;
    logic [VAL_W-1:0]   cell_val [LIST_DEPTH];
    logic [VAL_W-1:0]   cell_tap [LIST_DEPTH];

    assign pos_ext   = CMP_W'(pos_reg);
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_reg == FULL_COUNT);

    always_comb
    begin
        cmd        = CMD_HOLD;
        exec_stat  = STAT_OK;
        exec_count = count_reg;
        unique case (op_reg)
            OP_CLEAR:
            begin
                exec_count = '0;
            end
            OP_APPEND:
            begin
                if (full)
                    exec_stat = STAT_FULL;
                else
                begin
                    cmd        = CMD_WRITE;
                    exec_count = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_INSERT:
            begin
                if (full)
                    exec_stat = STAT_FULL;
                else if (pos_ext > count_ext)
                    exec_stat = STAT_RANGE;
                else
                begin
                    cmd        = CMD_INSERT;
                    exec_count = CNT_W'(count_reg + 1'b1);
                end
            end
            OP_DELETE:
            begin
                if (pos_ext >= count_ext)
                    exec_stat = STAT_RANGE;
                else
                begin
                    cmd        = CMD_DELETE;
                    exec_count = CNT_W'(count_reg - 1'b1);
                end
            end
            OP_UPDATE:
            begin
                if (pos_ext >= count_ext)
                    exec_stat = STAT_RANGE;
                else
                    cmd = CMD_WRITE;
            end
            OP_READ:
            begin
                if (pos_ext >= count_ext)
                    exec_stat = STAT_RANGE;
                else
                    cmd = CMD_READ;
            end
            default:
            begin
                cmd = CMD_HOLD;
            end
        endcase
    end

    always_comb
    begin
        ctrl.cmd   = (state_reg == ST_EXEC) ? cmd : CMD_HOLD;
        ctrl.pos   = (op_reg == OP_APPEND) ? count_ext : pos_ext;
        ctrl.count = count_ext;
        ctrl.val   = val_reg;
    end

    for (genvar g = 0; g < LIST_DEPTH; g++)
    begin : g_cell
        logic [VAL_W-1:0] below;
        logic [VAL_W-1:0] above;

        if (g == 0)
        begin : g_first
            assign below = '0;
        end
        else
        begin : g_mid_lo
            assign below = cell_val[g-1];
        end

        if (g == LIST_DEPTH - 1)
        begin : g_last
            assign above = '0;
        end
        else
        begin : g_mid_hi
            assign above = cell_val[g+1];
        end

        pal_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .index (CMP_W'(g)),
            .below (below),
            .above (above),
            .value (cell_val[g]),
            .tap   (cell_tap[g])
        );
    end

    pal_fold u_fold (
        .clk  (clk),
        .load (state_reg == ST_EXEC),
        .leaf (cell_tap),
        .sum  (fold_sum)
    );

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        count_next  = count_reg;
        stat_next   = stat_reg;
        ovalid_next = ovalid_reg;
        ord_next    = ord_reg;
        otot_next   = otot_reg;
        ostat_next  = ostat_reg;

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[OP_W-1:0];
                    pos_next   = s_tdata[OP_W+POS_W-1:OP_W];
                    val_next   = s_tdata[IN_RAW_W-1:OP_W+POS_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                count_next = exec_count;
                stat_next  = exec_stat;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ord_next    = fold_sum;
                    otot_next   = TOTAL_W'(count_reg);
                    ostat_next  = stat_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= '0;
            pos_reg    <= '0;
            val_reg    <= '0;
            count_reg  <= '0;
            stat_reg   <= STAT_OK;
            ovalid_reg <= 1'b0;
            ord_reg    <= '0;
            otot_reg   <= '0;
            ostat_reg  <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            pos_reg    <= pos_next;
            val_reg    <= val_next;
            count_reg  <= count_next;
            stat_reg   <= stat_next;
            ovalid_reg <= ovalid_next;
            ord_reg    <= ord_next;
            otot_reg   <= otot_next;
            ostat_reg  <= ostat_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = OUT_W'({ostat_reg, otot_reg, ord_reg});

    `PAL_ASSERT(a_count_bound, count_reg <= FULL_COUNT)
    `PAL_ASSERT_NEXT(a_accept_exec, s_tvalid && s_tready, state_reg == ST_EXEC)
    `PAL_ASSERT_NEXT(a_count_quiet, state_reg != ST_EXEC, $stable(count_reg))
    `PAL_ASSERT_IMPL(a_full_flag, state_reg == ST_FOLD && stat_reg == STAT_FULL,
                     count_reg == FULL_COUNT)

endmodule

// File: tb/sv/positional_array_list_test.sv
// Self-checking testbench for the positional array list stream block.
`timescale 1ns / 1ps

import pal_pkg::*;

localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

typedef struct {
    logic [VAL_W-1:0]   read_value;
    logic [TOTAL_W-1:0] element_total;
    logic [STAT_W-1:0]  status;
} list_result_t;

class list_mirror;
    logic [VAL_W-1:0] cells [LIST_DEPTH];
    int unsigned      count;
    list_result_t     pending_results [$];
    int unsigned      mismatches;

    function new();
        count      = 0;
        mismatches = 0;
    endfunction

    function int unsigned outstanding();
        return pending_results.size();
    endfunction

    task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
        if (mismatches < 50)
            $display("positional_array_list_test: %s mismatch at %0t: got %0h, expected %0h",
                     what, $realtime, got, want);
        mismatches++;
    endtask

    task apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        list_result_t r;
        int unsigned  i;
        r.read_value = '0;
        r.status     = STAT_OK;
        case (op)
            OP_CLEAR:
                count = 0;
            OP_APPEND:
                if (count >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    cells[count] = val;
                    count++;
                end
            OP_INSERT:
                if (count >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else if (pos > count)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = count; i > pos; i--)
                        cells[i] = cells[i - 1];
                    cells[pos] = val;
                    count++;
                end
            OP_DELETE:
                if (pos >= count)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = pos; i + 1 < count; i++)
                        cells[i] = cells[i + 1];
                    count--;
                end
            OP_UPDATE:
                if (pos >= count)
                    r.status = STAT_RANGE;
                else
                    cells[pos] = val;
            OP_READ:
                if (pos >= count)
                    r.status = STAT_RANGE;
                else
                    r.read_value = cells[pos];
            default:
                ;
        endcase
        r.element_total = count[TOTAL_W-1:0];
        pending_results.push_back(r);
    endtask

    task check_result(logic [OUT_W-1:0] word);
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected word", word[VAL_W-1:0], '0);
            return;
        end
        want = pending_results.pop_front();
        if (word[31:0] !== want.read_value)
            report("read_value", word[31:0], want.read_value);
        if (word[39:32] !== want.element_total)
            report("element_total", word[39:32], want.element_total);
        if (word[41:40] !== want.status)
            report("status", word[41:40], want.status);
    endtask
endclass

module positional_array_list_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1900;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    list_mirror tracker = new();
    bit         hold_req = 1'b0;
    int         burst_left = 0;
    int         no_gap_left = 0;
    int         cycle_count = 0;

    positional_array_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("positional_array_list_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    initial
    begin : receiver
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(16, 160);
            end
            left--;
            tick++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((tick % 5) < 2);
            endcase
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                logic [VAL_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            gap = (no_gap_left > 0) ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        burst_left--;
        if (no_gap_left > 0)
            no_gap_left--;
        s_tdata  <= IN_W'({val, pos, op});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.apply_request(op, pos, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
        burst_left = 0;
    endtask

    task automatic random_request(int target);
        int                r;
        int                cnt;
        logic [OP_W-1:0]   op;
        logic [POS_W-1:0]  pos;
        cnt = tracker.count;
        r   = $urandom_range(0, 99);
        pos = POS_W'($urandom_range(0, 127));
        if (r < 4)
            op = OP_W'($urandom_range(0, 7));
        else if (r < 5)
            op = OP_CLEAR;
        else if (r < 60)
        begin
            if (cnt < target)
                op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
            else if (cnt > target)
                op = OP_DELETE;
            else
                case ($urandom_range(0, 2))
                    0:       op = OP_APPEND;
                    1:       op = OP_INSERT;
                    default: op = OP_DELETE;
                endcase
        end
        else
            op = $urandom_range(0, 1) ? OP_UPDATE : OP_READ;
        if (r >= 5 && $urandom_range(0, 11) != 0)
        begin
            if (op == OP_INSERT)
                pos = POS_W'($urandom_range(0, (cnt > 127) ? 127 : cnt));
            else if (cnt > 0)
                pos = POS_W'($urandom_range(0, cnt - 1));
        end
        push_request(op, pos, pick_value());
    endtask

    initial
    begin : stimulus
        int n;
        int target;
        target = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_request(OP_READ,   7'd0,   32'h1111_1111);
        push_request(OP_DELETE, 7'd0,   32'h0);
        push_request(OP_UPDATE, 7'd0,   32'h2222_2222);
        push_request(OP_INSERT, 7'd1,   32'h3333_3333);
        push_request(OP_INSERT, 7'd0,   32'h8000_0000);
        push_request(OP_APPEND, 7'd0,   32'h7fff_ffff);
        push_request(OP_APPEND, 7'd127, 32'hffff_ffff);
        push_request(OP_APPEND, 7'd0,   32'h0000_0000);
        push_request(OP_INSERT, 7'd2,   32'h5555_5555);
        push_request(OP_INSERT, 7'd5,   32'haaaa_aaaa);
        push_request(OP_INSERT, 7'd7,   32'h4444_4444);
        push_request(OP_READ,   7'd0,   32'h0);
        push_request(OP_READ,   7'd1,   32'h0);
        push_request(OP_READ,   7'd2,   32'h0);
        push_request(OP_READ,   7'd5,   32'h0);
        push_request(OP_UPDATE, 7'd5,   32'h1234_5678);
        push_request(OP_READ,   7'd5,   32'h0);
        push_request(OP_DELETE, 7'd0,   32'h0);
        push_request(OP_DELETE, 7'd4,   32'h0);
        push_request(OP_READ,   7'd127, 32'h0);
        push_request(OP_UNUSED_A, 7'd3, 32'hdead_beef);
        push_request(OP_UNUSED_B, 7'd127, 32'hffff_ffff);
        push_request(OP_CLEAR,  7'd0,   32'h0);
        push_request(OP_READ,   7'd0,   32'h0);
        wait_drained();

        while (tracker.count < LIST_DEPTH)
            push_request(OP_APPEND, POS_W'($urandom_range(0, 127)), pick_value());
        push_request(OP_APPEND, 7'd0,   32'h7fff_ffff);
        push_request(OP_INSERT, 7'd0,   32'h8000_0000);
        push_request(OP_INSERT, 7'd127, 32'h0);
        push_request(OP_READ,   7'd127, 32'h0);
        push_request(OP_UPDATE, 7'd127, 32'hffff_ffff);
        push_request(OP_READ,   7'd127, 32'h0);
        push_request(OP_DELETE, 7'd127, 32'h0);
        push_request(OP_READ,   7'd127, 32'h0);
        push_request(OP_INSERT, 7'd127, 32'h8000_0001);
        push_request(OP_DELETE, 7'd0,   32'h0);
        push_request(OP_READ,   7'd0,   32'h0);
        wait_drained();

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 120 == 0)
                case ($urandom_range(0, 5))
                    0:       target = 0;
                    1:       target = LIST_DEPTH;
                    default: target = $urandom_range(1, LIST_DEPTH - 1);
                endcase
            if (n == 500 || n == 1300)
            begin
                hold_req    = 1'b1;
                no_gap_left = 250;
            end
            if (n == 950)
                wait_drained();
            random_request(target);
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
        repeat (12) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("positional_array_list_test: PASS");
        else
            $display("positional_array_list_test: FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/pal_pkg.sv
src/pal_cell.sv
src/pal_fold.sv
src/positional_array_list.sv
tb/sv/positional_array_list_test.sv
